/* src/lsplpc_pkg.sv */
// Package for the LSP to LPC converter: payload structs, widths and types.
// No dependencies.
package lsplpc_pkg;
  localparam int NumLsp = 10;
  localparam int NumStages = 5;
  localparam int CoefW = 40;

  typedef logic signed [CoefW-1:0] coef_t;

  typedef struct packed {
    logic signed [15:0] lsp_0;
    logic signed [15:0] lsp_1;
    logic signed [15:0] lsp_2;
    logic signed [15:0] lsp_3;
    logic signed [15:0] lsp_4;
    logic signed [15:0] lsp_5;
    logic signed [15:0] lsp_6;
    logic signed [15:0] lsp_7;
    logic signed [15:0] lsp_8;
    logic signed [15:0] lsp_9;
  } lsp_in_t;

  typedef struct packed {
    logic signed [15:0] lpc_1;
    logic signed [15:0] lpc_2;
    logic signed [15:0] lpc_3;
    logic signed [15:0] lpc_4;
    logic signed [15:0] lpc_5;
    logic signed [15:0] lpc_6;
    logic signed [15:0] lpc_7;
    logic signed [15:0] lpc_8;
    logic signed [15:0] lpc_9;
    logic signed [15:0] lpc_10;
    logic               clipped;
  } lpc_out_t;

  typedef coef_t poly_t [6];
endpackage

/* src/lsplpc_lane.sv */
// One polynomial lane: five pipelined stages of the product expansion.
// Depends on lsplpc_pkg.
module lsplpc_lane import lsplpc_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] q [NumStages],
  output coef_t              p_out [6]
);
  coef_t p [NumStages+1][6];
  logic signed [15:0] qd [NumStages][NumStages];

  for (genvar j = 0; j < 6; j++) begin : g_init
    assign p[0][j] = (j == 0) ? coef_t'(1 << 24) : coef_t'(0);
  end
  assign qd[0] = q;

  // Stage k holds p after k factors plus the cosines still to be used.
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    coef_t nxt [6];
    coef_t pr [6];

    always_comb begin
      logic signed [CoefW+15:0] prod;
      prod = '0;
      nxt[0] = p[k][0];
      for (int j = 1; j < 6; j++) begin
        if (j <= 2*(k+1)) begin
          prod = p[k][j-1] * qd[k][k];
          nxt[j] = p[k][j] - coef_t'(prod >>> 14);
          if (j >= 2) nxt[j] = nxt[j] + p[k][j-2];
        end else begin
          nxt[j] = p[k][j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) pr <= nxt;
    end
    assign p[k+1] = pr;

    // Carry the cosines along with the partial product.
    if (k < NumStages-1) begin : g_carry
      logic signed [15:0] qr [NumStages];
      always_ff @(posedge clk) begin
        if (adv) qr <= qd[k];
      end
      assign qd[k+1] = qr;
    end
  end

  assign p_out = p[NumStages];
endmodule

/* src/lsplpc_merge.sv */
// Merge stage: fold in 1+z^-1 / 1-z^-1, round, saturate, flag.
// Depends on lsplpc_pkg.
module lsplpc_merge import lsplpc_pkg::*; (
  input  coef_t    f1 [6],
  input  coef_t    f2 [6],
  output lpc_out_t res
);
  function automatic logic [16:0] to_q12(input coef_t v);
    coef_t r;
    r = (v + coef_t'(4096)) >>> 13;
    if (r > coef_t'(32767)) return {1'b1, 16'h7fff};
    if (r < -coef_t'(32768)) return {1'b1, 16'h8000};
    return {1'b0, r[15:0]};
  endfunction

  always_comb begin
    coef_t a [1:5];
    coef_t b [1:5];
    logic [16:0] s [1:5];
    logic [16:0] d [1:5];
    for (int i = 1; i < 6; i++) begin
      a[i] = f1[i] + f1[i-1];
      b[i] = f2[i] - f2[i-1];
      s[i] = to_q12(a[i] + b[i]);
      d[i] = to_q12(a[i] - b[i]);
    end
    res.lpc_1 = s[1][15:0];  res.lpc_2 = s[2][15:0];  res.lpc_3 = s[3][15:0];
    res.lpc_4 = s[4][15:0];  res.lpc_5 = s[5][15:0];
    res.lpc_10 = d[1][15:0]; res.lpc_9 = d[2][15:0];  res.lpc_8 = d[3][15:0];
    res.lpc_7 = d[4][15:0];  res.lpc_6 = d[5][15:0];
    res.clipped = s[1][16] | s[2][16] | s[3][16] | s[4][16] | s[5][16] |
                  d[1][16] | d[2][16] | d[3][16] | d[4][16] | d[5][16];
  end
endmodule

/* src/lsp_to_lpc_convert_top.sv */
// Top level of the order-10 LSP to LPC converter.
// Depends on lsplpc_pkg, lsplpc_lane, lsplpc_merge.
//
// channel | signals                   | payload
// in      | in_valid, in_ready, in    | lsp_in_t, ten Q15 cosines
// out     | out_valid, out_ready, out | lpc_out_t, ten Q12 coefficients + clipped
//
// One item per cycle sustained while the output is taken. An accepted item
// passes through five lane stages (one multiply-add factor each, both lanes
// side by side), the last of which feeds the merge logic straight into the
// output register.
// The whole pipeline advances together; it stalls only when the output
// register is full and not taken. Reset clears the valid bits only.
module lsp_to_lpc_convert_top import lsplpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lsp_in_t  in,
  output logic     out_valid,
  input  logic     out_ready,
  output lpc_out_t out
);
  logic [NumStages-1:0] vld;
  logic adv;
  logic signed [15:0] qe [NumStages];
  logic signed [15:0] qo [NumStages];
  coef_t f1 [6];
  coef_t f2 [6];
  lpc_out_t res;

  // Advance whenever the output slot is empty or being drained.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  assign qe = '{in.lsp_0, in.lsp_2, in.lsp_4, in.lsp_6, in.lsp_8};
  assign qo = '{in.lsp_1, in.lsp_3, in.lsp_5, in.lsp_7, in.lsp_9};

  lsplpc_lane u_even (.clk, .adv, .q(qe), .p_out(f1));
  lsplpc_lane u_odd  (.clk, .adv, .q(qo), .p_out(f2));
  lsplpc_merge u_merge (.f1, .f2, .res);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], in_valid};
      out_valid <= vld[NumStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out <= res;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out)) else $error("output dropped");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && vld[NumStages-1] |=> out_valid) else $error("item lost");
endmodule

/* sim/tb_lsp_to_lpc_convert_top.sv */
// Testbench for lsp_to_lpc_convert_top: random and directed LSP vectors against
// an in-bench fixed-point LSP to LPC predictor. Depends on lsplpc_pkg and the top.
`timescale 1ns / 100ps

module tb_lsp_to_lpc_convert_top;
  import lsplpc_pkg::*;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  lsp_in_t  in;
  logic     out_valid;
  logic     out_ready;
  lpc_out_t out;

  lsp_to_lpc_convert_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in(in),
    .out_valid(out_valid), .out_ready(out_ready), .out(out)
  );

  lsp_in_t  pending_lsp[$];
  lpc_out_t expected_lpc[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       cycle_no = 0;
  bit       stim_done = 0;
  bit       no_idle;

  // Long stretch with no idling on either side.
  assign no_idle = (cycle_no > 1500 && cycle_no < 2500);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Arithmetic shift right on a 64-bit signed value (floor).
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // Expand five cosines into coefficients 0..5 of prod (1 - 2q z^-1 + z^-2), Q24.
  function automatic void expand_poly(input longint q[5], output longint p[6]);
    longint t;
    int top;
    for (int j = 0; j < 6; j++) p[j] = 0;
    p[0] = longint'(1) << 24;
    for (int k = 0; k < 5; k++) begin
      top = (2 * (k + 1) > 5) ? 5 : 2 * (k + 1);
      for (int j = top; j >= 1; j--) begin
        t = p[j] - asr(p[j-1] * q[k], 14);
        if (j >= 2) t += p[j-2];
        p[j] = t;
      end
    end
  endfunction

  // Halve, move Q24 to Q12 with round half up, saturate.
  function automatic logic signed [15:0] round_q12(longint v, ref bit sat);
    longint r;
    r = asr(v + (longint'(1) << 12), 13);
    if (r > 32767) begin
      r = 32767;
      sat = 1;
    end else if (r < -32768) begin
      r = -32768;
      sat = 1;
    end
    return r[15:0];
  endfunction

  function automatic lpc_out_t lpc_from_lsp(lsp_in_t v);
    longint qe[5], qo[5], f1[6], f2[6];
    logic signed [15:0] a[10];
    logic [16*10-1:0] flat;
    bit sat;
    lpc_out_t r;
    flat = v;
    sat = 0;
    // Field lsp_0 sits at the top of the packed struct.
    for (int i = 0; i < 5; i++) begin
      qe[i] = longint'($signed(flat[16*(9-2*i) +: 16]));
      qo[i] = longint'($signed(flat[16*(8-2*i) +: 16]));
    end
    expand_poly(qe, f1);
    expand_poly(qo, f2);
    for (int i = 5; i >= 1; i--) begin
      f1[i] += f1[i-1];
      f2[i] -= f2[i-1];
    end
    for (int i = 1; i <= 5; i++) begin
      a[i-1]  = round_q12(f1[i] + f2[i], sat);
      a[10-i] = round_q12(f1[i] - f2[i], sat);
    end
    r = {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8], a[9], sat};
    return r;
  endfunction

  function automatic logic [15:0] rand_cos();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Sorted descending cosines, as real quantized LSPs would be.
  function automatic lsp_in_t ordered_lsp();
    logic [15:0] c[10];
    logic [15:0] tmp;
    for (int i = 0; i < 10; i++) c[i] = 16'($urandom());
    for (int i = 0; i < 10; i++)
      for (int j = i + 1; j < 10; j++)
        if ($signed(c[j]) > $signed(c[i])) begin
          tmp = c[i];
          c[i] = c[j];
          c[j] = tmp;
        end
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9]};
  endfunction

  initial begin
    lsp_in_t v;
    // Extremes: all -1, all just under +1, zero, alternating signs, single hot lanes.
    pending_lsp.push_back({10{16'h8000}});
    pending_lsp.push_back({10{16'h7fff}});
    pending_lsp.push_back({10{16'h0000}});
    pending_lsp.push_back({10{16'hffff}});
    pending_lsp.push_back({5{16'h7fff, 16'h8000}});
    pending_lsp.push_back({5{16'h8000, 16'h7fff}});
    pending_lsp.push_back({10{16'h5555}});
    pending_lsp.push_back({10{16'haaaa}});
    for (int i = 0; i < 10; i++) begin
      v = {10{16'h0000}};
      v[16*i +: 16] = 16'h8000;
      pending_lsp.push_back(v);
    end
    for (int i = 0; i < 5; i++) pending_lsp.push_back(ordered_lsp());
    for (int n = 0; n < 2000; n++) begin
      if ($urandom_range(0, 2) != 0) pending_lsp.push_back(ordered_lsp());
      else begin
        for (int i = 0; i < 10; i++) v[16*i +: 16] = rand_cos();
        pending_lsp.push_back(v);
      end
    end
  end

  // Driver: hold valid and payload until taken, then advance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      in <= '0;
    end else begin
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready) expected_lpc.push_back(lpc_from_lsp(in));
        if (pending_lsp.size() > 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
          in <= pending_lsp.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
          if (pending_lsp.size() == 0) stim_done <= 1;
        end
      end
    end
  end

  // Monitor: compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    lpc_out_t exp_r;
    if (rst) begin
      out_ready <= 0;
    end else begin
      cycle_no <= cycle_no + 1;
      out_ready <= no_idle || ($urandom_range(0, 99) >= 32);
      if (out_valid && out_ready) begin
        if (expected_lpc.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out);
        end else begin
          exp_r = expected_lpc.pop_front();
          if (out !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h got %h", exp_r, out);
          end
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1;
    in_valid = 0;
    in = '0;
    out_ready = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    fork
      begin
        wait (stim_done && !in_valid && expected_lpc.size() == 0);
        repeat (20) @(posedge clk);
      end
      begin
        wait (quiet_cycles >= 2000);
        $display("[lsp_to_lpc_convert_top] ERROR");
        $finish;
      end
    join_any
    if (mismatches == 0 && expected_lpc.size() == 0) $display("[lsp_to_lpc_convert_top] OK");
    else $display("[lsp_to_lpc_convert_top] ERROR");
    $finish;
  end
endmodule
